[hdl/iirdf_pkg.sv]
package iirdf_pkg;

  localparam int FILTER_ORDER = 2;
  localparam int TAP_COUNT = (FILTER_ORDER > 3) ? 3 : ((FILTER_ORDER < 1) ? 1 : FILTER_ORDER);

  localparam int SAMPLE_W = 16;
  localparam int COEF_W = 16;
  localparam int FRAC_BITS = 14;
  localparam int PROD_W = SAMPLE_W + 1 + COEF_W;
  localparam int ACC_W = 36;
  localparam int STEP_W = $clog2(TAP_COUNT + 2);

  // coefficient registers that exist: b0..b2 and a1..a2
  localparam int NUM_FWD = 3;
  localparam int NUM_BACK = 2;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A2 = 3'd4;

  typedef struct packed {
    logic              load_x;
    logic              mul_en;
    logic              mul_ff;
    logic [STEP_W-1:0] tap;
    logic              acc_en;
    logic              w_load;
    logic              y_load;
  } iirdf_cmd_t;

  function automatic logic [SAMPLE_W-1:0] scale_sat(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-1:0] q;
    q = ACC_W'(acc >>> FRAC_BITS);
    if (acc <= 0) begin
      return '0;
    end else if (q[ACC_W-1:SAMPLE_W] != '0) begin
      return '1;
    end else begin
      return q[SAMPLE_W-1:0];
    end
  endfunction

endpackage

[hdl/iirdf_ctrl.sv]
module iirdf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output iirdf_pkg::iirdf_cmd_t cmd
);
  import iirdf_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FB   = 3'd1;
  localparam logic [2:0] ST_WSAT = 3'd2;
  localparam logic [2:0] ST_FF   = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [STEP_W-1:0] FB_LAST = STEP_W'(TAP_COUNT);
  localparam logic [STEP_W-1:0] FF_LAST = STEP_W'(TAP_COUNT + 1);

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              slot_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    cmd        = '0;
    cmd.tap    = step_r;
    case (state_r)
      ST_IDLE: begin
        cmd.load_x = in_tvalid;
        if (in_tvalid) begin
          state_nxt = ST_FB;
          step_nxt  = '0;
        end
      end
      ST_FB: begin
        cmd.mul_en = (step_r < FB_LAST);
        cmd.acc_en = (step_r != '0);
        if (step_r == FB_LAST) begin
          state_nxt = ST_WSAT;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_WSAT: begin
        cmd.w_load = 1'b1;
        state_nxt  = ST_FF;
      end
      ST_FF: begin
        cmd.mul_en = (step_r < FF_LAST);
        cmd.mul_ff = 1'b1;
        cmd.acc_en = (step_r != '0);
        if (step_r == FF_LAST) begin
          state_nxt = ST_DONE;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DONE: begin
        cmd.y_load = slot_free;
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.y_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hdl/iirdf_datapath.sv]
module iirdf_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  iirdf_pkg::iirdf_cmd_t               cmd,
  input  logic [iirdf_pkg::SAMPLE_W-1:0]      sample_in,
  output logic [iirdf_pkg::SAMPLE_W-1:0]      sample_out,
  input  logic                                cfg_wr_en,
  input  logic [iirdf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [iirdf_pkg::COEF_W-1:0]        cfg_wdata
);
  import iirdf_pkg::*;

  logic signed [COEF_W-1:0]  coef_b_r [NUM_FWD];
  logic signed [COEF_W-1:0]  coef_a_r [NUM_BACK];
  logic [SAMPLE_W-1:0]       dl_r [TAP_COUNT];
  logic [SAMPLE_W-1:0]       w_r;
  logic [SAMPLE_W-1:0]       y_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic [SAMPLE_W-1:0]       mul_a;
  logic signed [COEF_W-1:0]  mul_c;

  assign sample_out = y_r;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_c = '0;
    if (cmd.mul_ff) begin
      if (cmd.tap == '0) begin
        mul_a = w_r;
      end
      for (int i = 0; i < TAP_COUNT; i++) begin
        if (cmd.tap == STEP_W'(i + 1)) begin
          mul_a = dl_r[i];
        end
      end
      for (int i = 0; i < NUM_FWD; i++) begin
        if (cmd.tap == STEP_W'(i)) begin
          mul_c = coef_b_r[i];
        end
      end
    end else begin
      for (int i = 0; i < TAP_COUNT; i++) begin
        if (cmd.tap == STEP_W'(i)) begin
          mul_a = dl_r[i];
        end
      end
      for (int i = 0; i < NUM_BACK; i++) begin
        if (cmd.tap == STEP_W'(i)) begin
          mul_c = coef_a_r[i];
        end
      end
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.load_x) begin
      acc_nxt = $signed({{(ACC_W-SAMPLE_W-FRAC_BITS){1'b0}}, sample_in, {FRAC_BITS{1'b0}}});
    end else if (cmd.w_load) begin
      acc_nxt = '0;
    end else if (cmd.acc_en) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= PROD_W'($signed({1'b0, mul_a}) * mul_c);
    end
    acc_r <= acc_nxt;
    if (cmd.w_load) begin
      w_r <= scale_sat(acc_r);
    end
    if (cmd.y_load) begin
      y_r <= scale_sat(acc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAP_COUNT; i++) begin
        dl_r[i] <= '0;
      end
    end else if (cmd.y_load) begin
      for (int i = TAP_COUNT - 1; i > 0; i--) begin
        dl_r[i] <= dl_r[i-1];
      end
      dl_r[0] <= w_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_FWD; i++) begin
        coef_b_r[i] <= '0;
      end
      for (int i = 0; i < NUM_BACK; i++) begin
        coef_a_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_COEF_B0: coef_b_r[0] <= cfg_wdata;
        REG_COEF_B1: coef_b_r[1] <= cfg_wdata;
        REG_COEF_B2: coef_b_r[2] <= cfg_wdata;
        REG_COEF_A1: coef_a_r[0] <= cfg_wdata;
        REG_COEF_A2: coef_a_r[1] <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

endmodule

[hdl/iir_direct_form2_filter_core.sv]
// Second-order Direct Form II IIR filter on unsigned 16-bit samples with signed Q2.14
// coefficients b0, b1, b2, a1, a2 (feedback added as written, no sign flip). Per item
// w = x + a1*w1 + a2*w2 and y = b0*w + b1*w1 + b2*w2, each truncated toward zero and
// clamped to 0..65535; w then enters the delay line. One multiplier and accumulator are
// shared by all taps, so no new item is accepted until the last one is through: the item
// is loaded, the feedback pass runs, w is saturated, the forward pass runs (a product
// register sits in front of the accumulator in each pass), the result is loaded, and
// only then is ready high again in idle. The result register lets a new item be
// accepted while the previous result still waits; that item then holds in its last
// step until the waiting result is taken.
module iir_direct_form2_filter_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [15:0]                       in_tdata,   // sample_in
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [15:0]                       out_tdata,  // sample_out
  input  logic                              cfg_wr_en,
  input  logic [iirdf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [iirdf_pkg::COEF_W-1:0]      cfg_wdata
);
  import iirdf_pkg::*;

  iirdf_cmd_t cmd;

  iirdf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  iirdf_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sample_in  (in_tdata),
    .sample_out (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

endmodule
